>>> hw/rtl/fppc_pkg.sv
//------------------------------------------------------------------------------
// fppc_pkg
// Shared constants, types and helpers for the finger position P controller.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fppc_pkg;

    // default position width
    localparam int POSITION_WIDTH_DEF = 10;

    // speed and duty width
    localparam int SPEED_W = 8;

    // product of full speed and ramp offset
    localparam int PROD_W = 2 * SPEED_W;

    // error magnitudes below this give zero speed
    localparam int STOP_BAND = 20;
    // ramp length above the stop band
    localparam int RAMP_SPAN = 150;
    // error beyond this gives full speed
    localparam int FAR_BAND = STOP_BAND + RAMP_SPAN;

    // floor(p / 150) == (p * RECIP) >> RECIP_SHIFT for all p < 2^16 * 150 / 256
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(55925);

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_POS      = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_POS      = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPEED    = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED    = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_SPEED = CFG_ADDR_W'(4);
    localparam logic [CFG_ADDR_W-1:0] REG_MOTOR_ENABLE = CFG_ADDR_W'(5);

    // speed-related configuration
    typedef struct packed {
        logic [SPEED_W-1:0] min_speed;
        logic [SPEED_W-1:0] max_speed;
        logic [SPEED_W-1:0] target_speed;
        logic               motor_enable;
    } speed_cfg_t;

    // error classification carried from error stage to speed stage
    typedef struct packed {
        logic in_band;   // magnitude below the stop band
        logic far;       // magnitude beyond the ramp
        logic neg;       // error is negative
    } ramp_flags_t;

    // target speed clamped to [min_speed, max_speed]; if inverted, below min gives min, else max
    function automatic logic [SPEED_W-1:0] full_speed(input speed_cfg_t cfg);
        logic [SPEED_W-1:0] res;
        if (cfg.target_speed < cfg.min_speed)
            res = cfg.min_speed;
        else if (cfg.target_speed > cfg.max_speed)
            res = cfg.max_speed;
        else
            res = cfg.target_speed;
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fppc_error_stage.sv
//------------------------------------------------------------------------------
// fppc_error_stage
// Clamps the target, forms the position error and the ramp product.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fppc_error_stage
    import fppc_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      load,
    input  wire logic [POSITION_WIDTH-1:0] target_pos,
    input  wire logic [POSITION_WIDTH-1:0] measured_pos,
    input  wire logic [POSITION_WIDTH-1:0] min_pos,
    input  wire logic [POSITION_WIDTH-1:0] max_pos,
    input  wire speed_cfg_t                speed_cfg,
    output logic signed [POSITION_WIDTH:0] err_reg,
    output logic [PROD_W-1:0]              prod_reg,
    output ramp_flags_t                    flags_reg
);

    logic [POSITION_WIDTH-1:0] tgt_clamped;
    logic signed [POSITION_WIDTH:0] err_next;
    logic signed [POSITION_WIDTH:0] err_abs;
    logic [POSITION_WIDTH-1:0] mag;
    logic [SPEED_W-1:0] ramp_off;
    logic [PROD_W-1:0] prod_next;
    ramp_flags_t flags_next;

    // target clamp; if limits are inverted, below min gives min, all else max
    always_comb
    begin
        if (target_pos < min_pos)
            tgt_clamped = min_pos;
        else if (target_pos > max_pos)
            tgt_clamped = max_pos;
        else
            tgt_clamped = target_pos;
    end

    // error and magnitude
    always_comb
    begin
        err_next = $signed({1'b0, tgt_clamped}) - $signed({1'b0, measured_pos});
        err_abs  = err_next[POSITION_WIDTH] ? -err_next : err_next;
        mag      = err_abs[POSITION_WIDTH-1:0];
    end

    // classification and ramp product
    always_comb
    begin
        flags_next.neg     = err_next[POSITION_WIDTH];
        flags_next.in_band = (mag < POSITION_WIDTH'(STOP_BAND));
        flags_next.far     = (mag > POSITION_WIDTH'(FAR_BAND));
        ramp_off           = mag[SPEED_W-1:0] - SPEED_W'(STOP_BAND);
        prod_next          = PROD_W'(full_speed(speed_cfg)) * PROD_W'(ramp_off);
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg   <= err_next;
            prod_reg  <= prod_next;
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/fppc_speed_stage.sv
//------------------------------------------------------------------------------
// fppc_speed_stage
// Scales the ramp, saturates the speed and splits it into duty and direction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fppc_speed_stage
    import fppc_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire logic signed [POSITION_WIDTH:0] err,
    input  wire logic [PROD_W-1:0]          prod,
    input  wire ramp_flags_t                flags,
    input  wire speed_cfg_t                 speed_cfg,
    output logic [SPEED_W-1:0]              duty_reg,
    output logic                            dir_reg,
    output logic signed [POSITION_WIDTH:0]  err_out_reg
);

    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [SPEED_W-1:0] quot;
    logic [SPEED_W:0] mag_raw;
    logic [SPEED_W-1:0] mag_sat;
    logic [SPEED_W-1:0] duty_next;
    logic dir_next;

    // divide by the ramp span through the reciprocal
    always_comb
    begin
        scaled = (PROD_W+RECIP_W)'(prod) * (PROD_W+RECIP_W)'(RECIP);
        quot   = scaled[RECIP_SHIFT +: SPEED_W];
    end

    // speed magnitude from the error class
    always_comb
    begin
        if (flags.in_band)
            mag_raw = '0;
        else if (flags.far)
            mag_raw = {1'b0, full_speed(speed_cfg)};
        else
            mag_raw = {1'b0, speed_cfg.min_speed} + {1'b0, quot};
    end

    // saturation, enable, deadband split
    always_comb
    begin
        if (mag_raw > {1'b0, speed_cfg.max_speed})
            mag_sat = speed_cfg.max_speed;
        else
            mag_sat = mag_raw[SPEED_W-1:0];
        if (!speed_cfg.motor_enable)
            mag_sat = '0;

        if (mag_sat > speed_cfg.min_speed)
        begin
            duty_next = mag_sat;
            dir_next  = ~flags.neg;
        end
        else
        begin
            duty_next = '0;
            dir_next  = 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            duty_reg    <= duty_next;
            dir_reg     <= dir_next;
            err_out_reg <= err;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/finger_position_p_controller_top.sv
//------------------------------------------------------------------------------
// finger_position_p_controller_top
// Proportional position controller with deadband, stream in and stream out.
//------------------------------------------------------------------------------
// Pipeline: each input beat is registered in the error stage, then in the speed stage.
// Throughput: one beat per cycle while the output is ready; the two stage registers pass on stalls.
// Reset: asynchronous, active low; clears both stage valids and loads the
// register defaults (full position range, speeds 0/255/255, motor enabled).
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module finger_position_p_controller_top
    import fppc_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    localparam int IN_W  = ((2 * POSITION_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((POSITION_WIDTH + SPEED_W + 1 + 7) / 8) * 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration write port
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [POSITION_WIDTH-1:0] cfg_wdata,
    // input stream
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [IN_W-1:0]           s_tdata,   // target_pos, measured_pos
    // output stream
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [OUT_W-1:0]               m_tdata    // pwm_duty, direction, position_error
);

    logic [POSITION_WIDTH-1:0] min_pos_reg;
    logic [POSITION_WIDTH-1:0] max_pos_reg;
    speed_cfg_t speed_cfg_reg;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic accept;
    logic adv2;

    logic signed [POSITION_WIDTH:0] err1;
    logic [PROD_W-1:0] prod1;
    ramp_flags_t flags1;

    logic [SPEED_W-1:0] duty2;
    logic dir2;
    logic signed [POSITION_WIDTH:0] err2;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pos_reg                <= '0;
            max_pos_reg                <= '1;
            speed_cfg_reg.min_speed    <= '0;
            speed_cfg_reg.max_speed    <= '1;
            speed_cfg_reg.target_speed <= '1;
            speed_cfg_reg.motor_enable <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_POS:      min_pos_reg <= cfg_wdata;
                REG_MAX_POS:      max_pos_reg <= cfg_wdata;
                REG_MIN_SPEED:    speed_cfg_reg.min_speed <= cfg_wdata[SPEED_W-1:0];
                REG_MAX_SPEED:    speed_cfg_reg.max_speed <= cfg_wdata[SPEED_W-1:0];
                REG_TARGET_SPEED: speed_cfg_reg.target_speed <= cfg_wdata[SPEED_W-1:0];
                REG_MOTOR_ENABLE: speed_cfg_reg.motor_enable <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // stage handshake
    always_comb
    begin
        adv2     = v1_reg && (!v2_reg || m_tready);
        s_tready = !v1_reg || !v2_reg || m_tready;
        accept   = s_tvalid && s_tready;
        v1_next  = accept ? 1'b1 : (adv2 ? 1'b0 : v1_reg);
        v2_next  = adv2 ? 1'b1 : (m_tready ? 1'b0 : v2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // error stage
    fppc_error_stage #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_error_stage (
        .clk          (clk),
        .load         (accept),
        .target_pos   (s_tdata[POSITION_WIDTH-1:0]),
        .measured_pos (s_tdata[2*POSITION_WIDTH-1:POSITION_WIDTH]),
        .min_pos      (min_pos_reg),
        .max_pos      (max_pos_reg),
        .speed_cfg    (speed_cfg_reg),
        .err_reg      (err1),
        .prod_reg     (prod1),
        .flags_reg    (flags1)
    );

    // speed stage
    fppc_speed_stage #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_speed_stage (
        .clk         (clk),
        .load        (adv2),
        .err         (err1),
        .prod        (prod1),
        .flags       (flags1),
        .speed_cfg   (speed_cfg_reg),
        .duty_reg    (duty2),
        .dir_reg     (dir2),
        .err_out_reg (err2)
    );

    // output beat
    assign m_tvalid = v2_reg;
    assign m_tdata  = OUT_W'({err2, dir2, duty2});

endmodule

`default_nettype wire

>>> bench/tb.sv
//------------------------------------------------------------------------------
// tb
// Checks the finger position P controller against a cycle-free predictor of
// its speed law. Sensor samples go in through a bursty stream driver and drive
// commands are checked field by field at a stalling receiver, across several
// register settings that include the extremes and inverted limits.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import fppc_pkg::*;

    localparam int POS_W = POSITION_WIDTH_DEF;
    localparam int IN_W  = ((2 * POS_W + 7) / 8) * 8;
    localparam int OUT_W = ((POS_W + SPEED_W + 1 + 7) / 8) * 8;
    localparam int POS_MAX = (1 << POS_W) - 1;

    // indexes with no register behind them
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = CFG_ADDR_W'(6);
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = CFG_ADDR_W'(7);

    typedef struct {
        logic [POS_W-1:0] target;
        logic [POS_W-1:0] measured;
    } sample_t;

    typedef struct {
        logic [SPEED_W-1:0] duty;
        logic               dir;
        logic [POS_W:0]     err;
    } drive_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [POS_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // predictor copy of the registers
    int lim_min_pos = 0;
    int lim_max_pos = POS_MAX;
    int spd_min = 0;
    int spd_max = 255;
    int spd_target = 255;
    bit motor_on = 1'b1;

    sample_t sample_q[$];
    drive_t  drive_q[$];

    int fault_count = 0;
    int sample_count = 0;
    int result_count = 0;
    int setting_count = 0;
    int close_count = 0;
    int open_count = 0;
    int still_count = 0;

    finger_position_p_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // target_pos, measured_pos
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // pwm_duty, direction, position_error
    );

    always #5 clk = ~clk;

    // with inverted limits, below the low bound gives lo, all else gives hi
    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // expected drive command for one sensor sample
    function automatic drive_t compute_drive(input sample_t smp);
        drive_t res;
        int tgt;
        int err;
        int mag;
        int full;
        int speed;
        tgt  = clamp_int(int'(smp.target), lim_min_pos, lim_max_pos);
        err  = tgt - int'(smp.measured);
        mag  = (err < 0) ? -err : err;
        full = clamp_int(spd_target, spd_min, spd_max);
        if (mag < STOP_BAND)
            speed = 0;
        else if (err > FAR_BAND)
            speed = full;
        else if (err < -FAR_BAND)
            speed = -full;
        else
        begin
            speed = spd_min + (full * (mag - STOP_BAND)) / RAMP_SPAN;
            if (err < 0)
                speed = -speed;
        end
        speed = clamp_int(speed, -spd_max, spd_max);
        if (!motor_on)
            speed = 0;
        res.duty = '0;
        res.dir  = 1'b0;
        if (speed < -spd_min)
            res.duty = SPEED_W'(-speed);
        else if (speed > spd_min)
        begin
            res.duty = SPEED_W'(speed);
            res.dir  = 1'b1;
        end
        res.err = (POS_W + 1)'(err);
        return res;
    endfunction

    // one register write, mirrored into the predictor once it lands
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [POS_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            REG_MIN_POS:      lim_min_pos = int'(value);
            REG_MAX_POS:      lim_max_pos = int'(value);
            REG_MIN_SPEED:    spd_min = int'(value[SPEED_W-1:0]);
            REG_MAX_SPEED:    spd_max = int'(value[SPEED_W-1:0]);
            REG_TARGET_SPEED: spd_target = int'(value[SPEED_W-1:0]);
            REG_MOTOR_ENABLE: motor_on = value[0];
            default:          ;
        endcase
    endtask

    // full register set; junk goes into the bits above each width
    task automatic set_limits(input int pmin, input int pmax, input int smin, input int smax,
                              input int starget, input bit enable);
        write_reg(REG_MIN_POS, POS_W'(pmin));
        write_reg(REG_MAX_POS, POS_W'(pmax));
        write_reg(REG_MIN_SPEED, {2'($urandom_range(0, 3)), SPEED_W'(smin)});
        write_reg(REG_MAX_SPEED, {2'($urandom_range(0, 3)), SPEED_W'(smax)});
        write_reg(REG_TARGET_SPEED, {2'($urandom_range(0, 3)), SPEED_W'(starget)});
        write_reg(REG_MOTOR_ENABLE, {POS_W'($urandom_range(0, POS_MAX)) & ~POS_W'(1)} | enable);
        setting_count++;
    endtask

    task automatic add_sample(input int tgt, input int meas);
        sample_t smp;
        smp.target   = POS_W'(tgt);
        smp.measured = POS_W'(meas);
        sample_q.push_back(smp);
    endtask

    // mostly samples near the clamped target so the ramp is exercised
    task automatic add_random_samples(input int count);
        int tgt;
        int meas;
        repeat (count)
        begin
            tgt = $urandom_range(0, POS_MAX);
            if ($urandom_range(0, 9) < 6)
                meas = clamp_int(clamp_int(tgt, lim_min_pos, lim_max_pos)
                                 + int'($urandom_range(0, 400)) - 200, 0, POS_MAX);
            else
                meas = $urandom_range(0, POS_MAX);
            add_sample(tgt, meas);
        end
    endtask

    // wait until every sample went through and every command came back
    task automatic drain();
        while (sample_q.size() != 0 || drive_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // stream driver: bursts of random length with random gaps
    sample_t cur_sample;
    int burst_left = 0;
    int gap_left = 0;
    logic next_valid;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                drive_q.push_back(compute_drive(cur_sample));
                void'(sample_q.pop_front());
                sample_count++;
            end
            // a beat on offer stays put until taken
            if (!s_tvalid || s_tready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (sample_q.size() != 0)
                begin
                    next_valid = 1'b1;
                    cur_sample = sample_q[0];
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                    end
                    else
                        burst_left--;
                end
                s_tvalid <= next_valid;
                s_tdata  <= IN_W'({cur_sample.measured, cur_sample.target});
            end
        end
    end

    // receiver: checks each beat and stalls on its own pattern
    drive_t got;
    drive_t want;
    int rx_cycle = 0;
    int rx_mode = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic next_ready;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_cycle  = 0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.duty = m_tdata[SPEED_W-1:0];
                got.dir  = m_tdata[SPEED_W];
                got.err  = m_tdata[SPEED_W+1 +: POS_W+1];
                result_count++;
                if (drive_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, duty %0d dir %0d err %0d", $realtime,
                             got.duty, got.dir, $signed(got.err));
                    fault_count++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got.duty !== want.duty)
                    begin
                        $display("%0t: pwm_duty expected %0d actual %0d", $realtime,
                                 want.duty, got.duty);
                        fault_count++;
                    end
                    if (got.dir !== want.dir)
                    begin
                        $display("%0t: direction expected %0d actual %0d", $realtime,
                                 want.dir, got.dir);
                        fault_count++;
                    end
                    if (got.err !== want.err)
                    begin
                        $display("%0t: position_error expected %0d actual %0d", $realtime,
                                 $signed(want.err), $signed(got.err));
                        fault_count++;
                    end
                    if (want.duty == 0)
                        still_count++;
                    else if (want.dir)
                        close_count++;
                    else
                        open_count++;
                end
            end
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 2);
            // one long hold-off so the pipeline backs up into the input
            if (!hold_done && result_count >= 150)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       next_ready = 1'b1;
                    1:       next_ready = ($urandom_range(0, 2) != 0);
                    default: next_ready = (rx_cycle % 4 != 0);
                endcase
            end
            m_tready <= next_ready;
        end
    end

    // stimulus phases
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: band edges, ramp ends, full-scale positions
        add_sample(0, 0);
        add_sample(POS_MAX, POS_MAX);
        add_sample(POS_MAX, 0);
        add_sample(0, POS_MAX);
        add_sample(500, 481);
        add_sample(500, 480);
        add_sample(480, 500);
        add_sample(481, 500);
        add_sample(670, 500);
        add_sample(671, 500);
        add_sample(500, 670);
        add_sample(500, 671);
        add_sample(600, 500);
        add_sample(400, 500);
        add_sample(512, 511);
        add_sample(511, 512);
        add_random_samples(40);
        drain();

        // ordinary limits, with writes to indexes that hold nothing
        set_limits(100, 900, 30, 200, 150, 1'b1);
        write_reg(REG_SPARE_LO, POS_W'($urandom_range(0, POS_MAX)));
        write_reg(REG_SPARE_HI, POS_W'($urandom_range(0, POS_MAX)));
        add_sample(0, 100);
        add_sample(POS_MAX, 900);
        add_sample(POS_MAX, 700);
        add_sample(0, 300);
        add_random_samples(55);
        drain();

        // inverted position and speed limits
        set_limits(700, 300, 200, 100, 150, 1'b1);
        add_random_samples(50);
        drain();

        // motor disabled
        write_reg(REG_MOTOR_ENABLE, POS_W'(10'h3FE));
        add_random_samples(40);
        drain();

        // everything at the top but the target speed
        set_limits(POS_MAX, POS_MAX, 255, 255, 0, 1'b1);
        add_random_samples(40);
        drain();

        // everything at the bottom but the target speed
        set_limits(0, 0, 0, 0, 255, 1'b1);
        add_random_samples(40);
        drain();

        // random settings, motor mostly on and speeds mostly sensible
        repeat (4)
        begin
            set_limits($urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX),
                       $urandom_range(0, 80), $urandom_range(60, 255),
                       $urandom_range(0, 255), $urandom_range(0, 3) != 0);
            add_random_samples(45);
            drain();
        end

        repeat (10) @(negedge clk);
        $display("covered %0d samples under %0d register settings, %0d commands checked",
                 sample_count, setting_count, result_count);
        $display("commands seen: %0d close, %0d open, %0d stopped",
                 close_count, open_count, still_count);
        if (fault_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("timeout with %0d commands outstanding", drive_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> finger_position_p_controller_top.f
hw/rtl/fppc_pkg.sv
hw/rtl/fppc_error_stage.sv
hw/rtl/fppc_speed_stage.sv
hw/rtl/finger_position_p_controller_top.sv
bench/tb.sv
